>>> hw/rtl/random_removal_bag_top_assert.svh
// assertion macros for the random removal bag
`ifndef RANDOM_REMOVAL_BAG_TOP_ASSERT_SVH
`define RANDOM_REMOVAL_BAG_TOP_ASSERT_SVH

// same-cycle implication
`define RRB_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// next-cycle implication
`define RRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

>>> hw/rtl/rrb_pkg.sv
// types and constants shared by the random removal bag
package rrb_pkg;

    localparam int RRB_CAPACITY = 128;
    localparam int KIND_W       = 2;
    localparam int VALUE_W      = 32;
    localparam int RND_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 8;

    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [RND_W-1:0]          random_word;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] data;
        logic [STATUS_W-1:0]       status;
        logic [FILL_W-1:0]         fill;
    } out_item_t;

endpackage

>>> hw/rtl/random_removal_bag_top.sv
// random removal bag: push, random pop with gap closing, random peek
// push, full, empty and unused kinds go straight to the output stage; peek and pop run the
//   bit-serial remainder unit and read the picked slot, then pop moves entries above it down
// items are taken one at a time: the next item is accepted once the result of the last is
//   registered, also while that result waits in the output register
// reset clears the state, the count and the output valid; slot memory is not cleared
`include "random_removal_bag_top_assert.svh"

module random_removal_bag_top
    import rrb_pkg::*;
#(
    parameter int CAPACITY = RRB_CAPACITY
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CNTW = $clog2(RND_W);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CAPT  = 3'd3;
    localparam logic [2:0] S_SH_RD = 3'd4;
    localparam logic [2:0] S_SH_WR = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             held_reg, held_next;
    logic [KIND_W-1:0]         kind_reg, kind_next;
    logic [RND_W-1:0]          rnd_reg, rnd_next;
    logic [CW-1:0]             rem_reg, rem_next;
    logic [CNTW-1:0]           cnt_reg, cnt_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic signed [VALUE_W-1:0] res_data_reg, res_data_next;
    logic [STATUS_W-1:0]       res_status_reg, res_status_next;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_item_reg, m_item_next;

    logic signed [VALUE_W-1:0] slots_mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic                      mem_we;
    logic [IW-1:0]             mem_waddr;
    logic [IW-1:0]             mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    logic          accept;
    logic          full;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          trial_ge;
    logic [CW-1:0] nxt;

    assign accept   = s_valid && s_ready;
    assign full     = (held_reg >= CW'(CAPACITY));
    assign trial    = {rem_reg, rnd_reg[RND_W-1]};
    assign diff     = trial - {1'b0, held_reg};
    assign trial_ge = (trial >= {1'b0, held_reg});
    assign nxt      = CW'(idx_reg) + CW'(1);

    assign s_ready = (state_reg == S_IDLE) && aresetn;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next      = state_reg;
        held_next       = held_reg;
        kind_next       = kind_reg;
        rnd_next        = rnd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rdata_reg;
        mem_raddr       = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    kind_next       = s_item.kind;
                    rnd_next        = s_item.random_word;
                    rem_next        = '0;
                    cnt_next        = CNTW'(RND_W - 1);
                    res_data_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_DONE;
                    case (s_item.kind)
                        KIND_PUSH: begin
                            if (full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = held_reg[IW-1:0];
                                mem_wdata = s_item.value;
                                held_next = held_reg + CW'(1);
                            end
                        end
                        KIND_POP, KIND_PEEK: begin
                            if (held_reg == '0) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                state_next = S_DIV;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                rem_next = trial_ge ? diff[CW-1:0] : trial[CW-1:0];
                rnd_next = rnd_reg << 1;
                cnt_next = cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                mem_raddr  = rem_reg[IW-1:0];
                idx_next   = rem_reg[IW-1:0];
                state_next = S_CAPT;
            end
            S_CAPT: begin
                res_data_next   = rdata_reg;
                res_status_next = STAT_OK;
                state_next      = (kind_reg == KIND_POP) ? S_SH_RD : S_DONE;
            end
            S_SH_RD: begin
                if (nxt < held_reg) begin
                    mem_raddr  = nxt[IW-1:0];
                    state_next = S_SH_WR;
                end else begin
                    held_next  = held_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SH_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = rdata_reg;
                idx_next   = nxt[IW-1:0];
                state_next = S_SH_RD;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_item_next.data   = res_data_reg;
                    m_item_next.status = res_status_reg;
                    m_item_next.fill   = FILL_W'(held_reg);
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slots_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slots_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        rnd_reg        <= rnd_next;
        rem_reg        <= rem_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_item_reg     <= m_item_next;
    end

    `RRB_ASSERT_IMPLY(a_held_bound, aclk, aresetn, 1'b1, held_reg <= CW'(CAPACITY))
    `RRB_ASSERT_IMPLY(a_rem_bound, aclk, aresetn, state_reg == S_DIV, rem_reg < held_reg)
    `RRB_ASSERT_NEXT(a_push_grows, aclk, aresetn,
        accept && s_item.kind == KIND_PUSH && !full,
        held_reg == $past(held_reg) + CW'(1))
    `RRB_ASSERT_IMPLY(a_empty_result, aclk, aresetn,
        m_valid_reg && m_item_reg.status == STAT_EMPTY,
        m_item_reg.data == '0 && m_item_reg.fill == '0)

endmodule

>>> verif/tb_random_removal_bag_top.sv
// testbench for random_removal_bag_top: push, pop and peek items checked against a bag model
module tb_random_removal_bag_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrb_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_ITEMS = 665;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic signed [VALUE_W-1:0] bag_contents[$];
    out_item_t                 expected_results[$];
    int                        mismatch_count = 0;
    bit                        steady_flow    = 1'b0;

    random_removal_bag_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    function automatic logic [RND_W-1:0] rand_word();
        return RND_W'($urandom_range(0, 65535));
    endfunction

    function automatic out_item_t bag_model_step(input in_item_t it);
        out_item_t   res;
        int unsigned pick;
        res = '0;
        res.status = STAT_OK;
        case (it.kind)
            KIND_PUSH: begin
                if (bag_contents.size() >= RRB_CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    bag_contents = {bag_contents, it.value};
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (bag_contents.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    pick = int'(it.random_word) % bag_contents.size();
                    res.data = bag_contents[pick];
                    if (it.kind == KIND_POP) begin
                        bag_contents.delete(pick);
                    end
                end
            end
            default: begin
            end
        endcase
        res.fill = FILL_W'(bag_contents.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: exp %0d/%0d/%0d got %0d/%0d/%0d", $realtime, what,
                     want.data, want.status, want.fill, got.data, got.status, got.fill);
        end
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic signed [VALUE_W-1:0] value,
                           input logic [RND_W-1:0] rword);
        in_item_t it;
        int       gap;
        it.kind        = kind;
        it.value       = value;
        it.random_word = rword;
        if (!steady_flow && $urandom_range(99) < 30) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results = {expected_results, bag_model_step(it)};
    endtask

    task automatic wait_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_bag();
        send_op(KIND_POP, $urandom, 16'h0000);
        send_op(KIND_PEEK, $urandom, 16'hFFFF);
        send_op(KIND_UNUSED, $urandom, rand_word());
        send_op(KIND_POP, $urandom, 16'hFFFF);
    endtask

    task automatic test_value_extremes();
        send_op(KIND_PUSH, 32'sh7FFF_FFFF, 16'hFFFF);
        send_op(KIND_PUSH, 32'sh8000_0000, 16'h0000);
        send_op(KIND_PUSH, 32'sh0000_0000, rand_word());
        send_op(KIND_PUSH, 32'shFFFF_FFFF, rand_word());
        send_op(KIND_PUSH, 32'sh0000_0001, rand_word());
        send_op(KIND_PEEK, $urandom, 16'h0000);
        send_op(KIND_PEEK, $urandom, 16'hFFFF);
        send_op(KIND_PEEK, $urandom, 16'd3);
        send_op(KIND_UNUSED, $urandom, 16'hFFFF);
        send_op(KIND_POP, $urandom, 16'hFFFF);
        send_op(KIND_POP, $urandom, 16'd3);
        send_op(KIND_POP, $urandom, 16'd1);
        send_op(KIND_POP, $urandom, 16'h0000);
        send_op(KIND_POP, $urandom, 16'hFFFF);
        send_op(KIND_PEEK, $urandom, 16'd7);
        send_op(KIND_POP, $urandom, 16'd7);
    endtask

    task automatic test_capacity();
        while (bag_contents.size() < RRB_CAPACITY) begin
            send_op(KIND_PUSH, $urandom, rand_word());
        end
        send_op(KIND_PUSH, $urandom, rand_word());
        send_op(KIND_PUSH, 32'sh7FFF_FFFF, 16'hFFFF);
        send_op(KIND_PEEK, $urandom, 16'hFFFF);
        send_op(KIND_UNUSED, $urandom, rand_word());
        send_op(KIND_POP, $urandom, 16'h0000);
        send_op(KIND_PUSH, 32'sh8000_0000, rand_word());
        send_op(KIND_PUSH, $urandom, rand_word());
        send_op(KIND_PEEK, $urandom, 16'd127);
        // sender holds off until the bag has answered everything
        wait_results();
        while (bag_contents.size() > 0) begin
            send_op(KIND_POP, $urandom, rand_word());
        end
        send_op(KIND_PEEK, $urandom, rand_word());
    endtask

    task automatic test_random_mix();
        bit                  filling;
        int                  ceiling;
        int                  roll;
        logic [KIND_W-1:0]   kind;
        logic [RND_W-1:0]    rword;
        filling = 1'b1;
        ceiling = RRB_CAPACITY;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_flow = (n >= 300 && n < 450);
            if (n == 600) begin
                wait_results();
            end
            if (filling && bag_contents.size() >= ceiling) begin
                filling = 1'b0;
            end else if (!filling && bag_contents.size() == 0) begin
                filling = 1'b1;
                ceiling = ($urandom_range(3) == 0) ? RRB_CAPACITY : $urandom_range(4, 40);
            end
            roll = $urandom_range(99);
            if (roll < 2) begin
                kind = KIND_UNUSED;
            end else if (roll < (filling ? 72 : 22)) begin
                kind = KIND_PUSH;
            end else if (roll < (filling ? 90 : 80)) begin
                kind = KIND_POP;
            end else begin
                kind = KIND_PEEK;
            end
            case ($urandom_range(9))
                0: rword = 16'h0000;
                1: rword = 16'hFFFF;
                2: rword = RND_W'($urandom_range(0, 7));
                default: rword = rand_word();
            endcase
            send_op(kind, $urandom, rword);
        end
        steady_flow = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= aresetn && (steady_flow || $urandom_range(99) >= 30);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected item", '0, m_item);
            end else begin
                want = expected_results.pop_front();
                if (m_item.data !== want.data || m_item.status !== want.status ||
                    m_item.fill !== want.fill) begin
                    report_mismatch("wrong item", want, m_item);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("random_removal_bag_top: mismatch");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_bag();
        test_value_extremes();
        test_capacity();
        test_random_mix();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("random_removal_bag_top: match");
        end else begin
            $display("random_removal_bag_top: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/rrb_pkg.sv
hw/rtl/random_removal_bag_top.sv
verif/tb_random_removal_bag_top.sv
